// File: rtl/dclk_pkg.sv
// ----------------------------------------------------------------------------
// dclk_pkg: shared definitions for the digital clock with display scan
// Widths, reset values, register indexes and the digit decode helpers.
// ----------------------------------------------------------------------------
package dclk_pkg;

    localparam int DIGITS       = 4;
    localparam int PERIOD_W     = 16;
    localparam int SCAN_POS_W   = $clog2(DIGITS);
    localparam int HOUR_W       = 5;
    localparam int MIN_W        = 6;
    localparam int SEC_W        = 6;
    localparam int SEG_W        = 7;

    localparam int SEC_MODULUS  = 60;
    localparam int MIN_MODULUS  = 60;
    localparam int HOUR_MODULUS = 24;

    localparam int HOUR_RESET   = 15;
    localparam int MIN_RESET    = 8;
    localparam int SEC_RESET    = 50;

    localparam logic [PERIOD_W-1:0] SECOND_PERIOD_RESET = PERIOD_W'(100);
    localparam logic [PERIOD_W-1:0] SCAN_PERIOD_RESET   = PERIOD_W'(25);

    // Configuration register indexes.
    typedef enum logic [0:0] {
        REG_SECOND_PERIOD = 1'b0,
        REG_SCAN_PERIOD   = 1'b1
    } t_reg_index;

    // Tens digit of a value below sixty, found by a short compare chain.
    function automatic logic [3:0] tens_of(input logic [MIN_W-1:0] value);
        logic [3:0] tens;
        tens = 4'd0;
        if (value >= MIN_W'(50)) begin
            tens = 4'd5;
        end else if (value >= MIN_W'(40)) begin
            tens = 4'd4;
        end else if (value >= MIN_W'(30)) begin
            tens = 4'd3;
        end else if (value >= MIN_W'(20)) begin
            tens = 4'd2;
        end else if (value >= MIN_W'(10)) begin
            tens = 4'd1;
        end
        return tens;
    endfunction

    function automatic logic [3:0] units_of(input logic [MIN_W-1:0] value);
        logic [MIN_W-1:0] tens_x10;
        logic [MIN_W-1:0] rest;
        tens_x10 = MIN_W'({tens_of(value), 3'b000}) + MIN_W'({tens_of(value), 1'b0});
        rest     = value - tens_x10;
        return rest[3:0];
    endfunction

    // Active-low common-anode segment codes for the digits 0 to 9.
    function automatic logic [SEG_W-1:0] seg_code(input logic [3:0] digit);
        logic [SEG_W-1:0] code;
        case (digit)
            4'd0:    code = 7'h40;
            4'd1:    code = 7'h79;
            4'd2:    code = 7'h24;
            4'd3:    code = 7'h30;
            4'd4:    code = 7'h19;
            4'd5:    code = 7'h12;
            4'd6:    code = 7'h02;
            4'd7:    code = 7'h78;
            4'd8:    code = 7'h00;
            4'd9:    code = 7'h10;
            default: code = 7'h7F;
        endcase
        return code;
    endfunction

endpackage

// File: rtl/digital_clock_with_7seg_scan.sv
// ----------------------------------------------------------------------------
// digital_clock_with_7seg_scan: HH:MM:SS clock driving a scanned display
// A chain of counter cells keeps the time; a scan stage multiplexes four digits.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                                   Direction
//  -------   ---------------------------------------   ---------
//  input     i_valid, o_ready, i_tick                   in
//  output    o_valid, i_ready, o_digit_enable_n,        out
//            o_segments_n, o_dot_level, o_hours,
//            o_minutes, o_seconds
//  config    i_cfg_we, i_cfg_index, i_cfg_data          in
//
// A new tick can be accepted each cycle unless the output side stalls.
// The time and display registers double as the output register: they change
// only when a beat is accepted, and a beat is accepted only when the pending
// result is taken in the same cycle or none is pending. Reset is synchronous
// and puts the clock at 15:08:50 with all digits enabled. A stall on the
// output side holds o_ready low, which holds the time and the display.
//
module digital_clock_with_7seg_scan
    import dclk_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Input channel
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_tick,
    // Output channel
    output logic                o_valid,
    input  logic                i_ready,
    output logic [DIGITS-1:0]   o_digit_enable_n,
    output logic [SEG_W-1:0]    o_segments_n,
    output logic                o_dot_level,
    output logic [HOUR_W-1:0]   o_hours,
    output logic [MIN_W-1:0]    o_minutes,
    output logic [SEC_W-1:0]    o_seconds,
    // Configuration write port
    input  logic                i_cfg_we,
    input  logic [0:0]          i_cfg_index,
    input  logic [PERIOD_W-1:0] i_cfg_data
);

    logic                  r_out_valid;
    logic                  accept;
    logic                  step;
    logic                  sec_fire;
    logic                  scan_fire;
    logic                  load_sec;
    logic                  load_scan;

    logic                  sec_carry;
    logic                  min_carry;
    logic                  hour_carry;
    logic                  hour_wrap;

    logic [HOUR_W-1:0]     hour_now;
    logic [MIN_W-1:0]      min_now;
    logic [SEC_W-1:0]      sec_now;
    logic [HOUR_W-1:0]     hour_next;
    logic [MIN_W-1:0]      min_next;

    logic [SCAN_POS_W-1:0] r_scan_pos;
    logic [SCAN_POS_W-1:0] n_scan_pos;
    logic [DIGITS-1:0]     r_enable_n;
    logic [DIGITS-1:0]     n_enable_n;
    logic [SEG_W-1:0]      r_segments_n;
    logic [SEG_W-1:0]      n_segments_n;
    logic                  r_dot;
    logic                  n_dot;
    logic [3:0]            digit;

    // Handshake: a new beat enters whenever the pending result leaves.
    assign o_ready = !r_out_valid || i_ready;
    assign accept  = i_valid && o_ready;
    assign step    = accept && i_tick;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Period registers and their countdowns. A write reloads the countdown.
    assign load_sec  = i_cfg_we && (t_reg_index'(i_cfg_index) == REG_SECOND_PERIOD);
    assign load_scan = i_cfg_we && (t_reg_index'(i_cfg_index) == REG_SCAN_PERIOD);

    dclk_countdown #(
        .RESET_PERIOD (SECOND_PERIOD_RESET)
    ) u_sec_countdown (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (load_sec),
        .i_period (i_cfg_data),
        .i_tick   (step),
        .o_fire   (sec_fire)
    );

    dclk_countdown #(
        .RESET_PERIOD (SCAN_PERIOD_RESET)
    ) u_scan_countdown (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (load_scan),
        .i_period (i_cfg_data),
        .i_tick   (step),
        .o_fire   (scan_fire)
    );

    // Time-of-day chain: seconds hand a carry to minutes, minutes to hours.
    assign sec_carry = sec_fire;

    dclk_count_cell #(
        .WIDTH     (SEC_W),
        .MODULUS   (SEC_MODULUS),
        .RESET_VAL (SEC_RESET)
    ) u_sec_cell (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_carry (sec_carry),
        .o_carry (min_carry),
        .o_count (sec_now)
    );

    dclk_count_cell #(
        .WIDTH     (MIN_W),
        .MODULUS   (MIN_MODULUS),
        .RESET_VAL (MIN_RESET)
    ) u_min_cell (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_carry (min_carry),
        .o_carry (hour_carry),
        .o_count (min_now)
    );

    dclk_count_cell #(
        .WIDTH     (HOUR_W),
        .MODULUS   (HOUR_MODULUS),
        .RESET_VAL (HOUR_RESET)
    ) u_hour_cell (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_carry (hour_carry),
        .o_carry (hour_wrap),
        .o_count (hour_now)
    );

    // The scan sees the time after this tick's update, so rebuild the
    // next hour and minute values from the carries of the chain.
    always_comb begin
        min_next = min_now;
        if (min_carry) begin
            min_next = hour_carry ? '0 : min_now + MIN_W'(1);
        end
        hour_next = hour_now;
        if (hour_carry) begin
            hour_next = hour_wrap ? '0 : hour_now + HOUR_W'(1);
        end
    end

    // Digit selection for the position being scanned in.
    always_comb begin
        case (r_scan_pos)
            2'd0:    digit = tens_of(MIN_W'(hour_next));
            2'd1:    digit = units_of(MIN_W'(hour_next));
            2'd2:    digit = tens_of(min_next);
            default: digit = units_of(min_next);
        endcase
    end

    always_comb begin
        n_scan_pos   = r_scan_pos;
        n_enable_n   = r_enable_n;
        n_segments_n = r_segments_n;
        n_dot        = r_dot;
        if (sec_fire) begin
            n_dot = !r_dot;
        end
        if (scan_fire) begin
            n_enable_n   = ~(DIGITS'(1) << r_scan_pos);
            n_segments_n = seg_code(digit);
            n_scan_pos   = r_scan_pos + SCAN_POS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_pos   <= '0;
            r_enable_n   <= '0;
            r_segments_n <= '0;
            r_dot        <= 1'b0;
        end else begin
            r_scan_pos   <= n_scan_pos;
            r_enable_n   <= n_enable_n;
            r_segments_n <= n_segments_n;
            r_dot        <= n_dot;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_digit_enable_n = r_enable_n;
    assign o_segments_n     = r_segments_n;
    assign o_dot_level      = r_dot;
    assign o_hours          = hour_now;
    assign o_minutes        = min_now;
    assign o_seconds        = sec_now;

endmodule

// File: rtl/dclk_count_cell.sv
// ----------------------------------------------------------------------------
// dclk_count_cell: one modulo counter cell of the time-of-day chain
// Advances on a carry from its lower neighbor and passes a carry on at wrap.
// ----------------------------------------------------------------------------
module dclk_count_cell
    import dclk_pkg::*;
#(
    parameter int WIDTH     = 6,
    parameter int MODULUS   = 60,
    parameter int RESET_VAL = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_carry,
    output logic             o_carry,
    output logic [WIDTH-1:0] o_count
);

    logic [WIDTH-1:0] r_count;
    logic [WIDTH-1:0] n_count;
    logic             at_top;

    assign at_top  = (r_count == WIDTH'(MODULUS - 1));
    assign o_carry = i_carry && at_top;
    assign o_count = r_count;

    always_comb begin
        n_count = r_count;
        if (i_carry) begin
            n_count = at_top ? '0 : r_count + WIDTH'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= WIDTH'(RESET_VAL);
        end else begin
            r_count <= n_count;
        end
    end

endmodule

// File: rtl/dclk_countdown.sv
// ----------------------------------------------------------------------------
// dclk_countdown: reloading tick countdown with its period register
// Fires when a tick brings the count from one to zero, then reloads.
// ----------------------------------------------------------------------------
module dclk_countdown
    import dclk_pkg::*;
#(
    parameter logic [PERIOD_W-1:0] RESET_PERIOD = SECOND_PERIOD_RESET
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  logic [PERIOD_W-1:0] i_period,
    input  logic                i_tick,
    output logic                o_fire
);

    logic [PERIOD_W-1:0] r_period;
    logic [PERIOD_W-1:0] r_count;
    logic [PERIOD_W-1:0] n_count;

    // A count parked at zero stays there until the period is rewritten.
    assign o_fire = i_tick && (r_count == PERIOD_W'(1));

    always_comb begin
        n_count = r_count;
        if (i_load) begin
            n_count = i_period;
        end else if (o_fire) begin
            n_count = r_period;
        end else if (i_tick && (r_count != '0)) begin
            n_count = r_count - PERIOD_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= RESET_PERIOD;
            r_count  <= RESET_PERIOD;
        end else begin
            if (i_load) begin
                r_period <= i_period;
            end
            r_count <= n_count;
        end
    end

endmodule

// File: test/digital_clock_with_7seg_scan_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// digital_clock_with_7seg_scan_tb: self-checking bench for the scanned clock
// Drives tick beats and period writes into the block and keeps a cycle-free
// model of the clock and the display scan. Every result beat is checked
// against that model, or against a hand-typed value in the opening script.
// ----------------------------------------------------------------------------
module digital_clock_with_7seg_scan_tb;
    import dclk_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 10;
    // Cycles without any beat on either channel before the run is abandoned.
    localparam int STALL_LIMIT  = 400;
    localparam int REPORT_MAX   = 10;
    localparam int PHASES       = 8;
    localparam int PHASE_TICKS  = 130;

    // Segment glyphs for 0..9, digit d at bits [7*d +: 7], active low.
    localparam logic [10*SEG_W-1:0] GLYPHS = {
        7'h10, 7'h00, 7'h78, 7'h02, 7'h12, 7'h19, 7'h30, 7'h24, 7'h79, 7'h40
    };

    // One result beat, as seen on the output channel.
    typedef struct packed {
        logic [DIGITS-1:0] enable_n;
        logic [SEG_W-1:0]  segments_n;
        logic              dot;
        logic [HOUR_W-1:0] hours;
        logic [MIN_W-1:0]  minutes;
        logic [SEC_W-1:0]  seconds;
    } t_readout;

    typedef enum logic {
        ROW_TICK,
        ROW_WRITE
    } t_row_kind;

    // One line of the opening script: a tick beat or a period write.
    typedef struct {
        t_row_kind           kind;
        t_reg_index          index;
        logic [PERIOD_W-1:0] value;
        logic                tick;
        bit                  typed;
        t_readout            want;
    } t_script_row;

    // ------------------------------------------------------------------------
    // Signals toward the block. Every input holds a known value from time 0.
    // ------------------------------------------------------------------------
    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                tick_valid = 1'b0;
    logic                tick_ready;
    logic                tick_bit = 1'b0;
    logic                readout_valid;
    logic                readout_ready = 1'b0;
    logic [DIGITS-1:0]   enable_n;
    logic [SEG_W-1:0]    segments_n;
    logic                dot_level;
    logic [HOUR_W-1:0]   hours;
    logic [MIN_W-1:0]    minutes;
    logic [SEC_W-1:0]    seconds;
    logic                cfg_we = 1'b0;
    t_reg_index          cfg_index = REG_SECOND_PERIOD;
    logic [PERIOD_W-1:0] cfg_data = '0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    digital_clock_with_7seg_scan i_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_valid          (tick_valid),
        .o_ready          (tick_ready),
        .i_tick           (tick_bit),
        .o_valid          (readout_valid),
        .i_ready          (readout_ready),
        .o_digit_enable_n (enable_n),
        .o_segments_n     (segments_n),
        .o_dot_level      (dot_level),
        .o_hours          (hours),
        .o_minutes        (minutes),
        .o_seconds        (seconds),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Clock model. It mirrors the block's state and is advanced at the very
    // edge where a tick beat is accepted, so its output is the value that the
    // block must put out for that beat.
    // ------------------------------------------------------------------------
    logic [PERIOD_W-1:0] second_reload;
    logic [PERIOD_W-1:0] scan_reload;
    logic [PERIOD_W-1:0] second_left;
    logic [PERIOD_W-1:0] scan_left;
    logic [HOUR_W-1:0]   hour_now;
    logic [MIN_W-1:0]    minute_now;
    logic [SEC_W-1:0]    second_now;
    logic [1:0]          scan_slot;
    logic [DIGITS-1:0]   shown_enable_n;
    logic [SEG_W-1:0]    shown_segments_n;
    logic                dot_now;

    t_readout readouts_due[$];

    // Bookkeeping for the summary and the verdict.
    int mismatches  = 0;
    int ticks_sent  = 0;
    int directed    = 0;
    int writes_done = 0;
    int checked     = 0;
    int midnights   = 0;
    int quiet_cycles = 0;

    // Stimulus controls shared between the driving processes.
    bit       idling_enabled = 1'b0;
    bit       row_typed = 1'b0;
    t_readout row_want = '0;
    int       stall_left = 0;

    function automatic void reset_clock_model();
        second_reload    = SECOND_PERIOD_RESET;
        scan_reload      = SCAN_PERIOD_RESET;
        second_left      = SECOND_PERIOD_RESET;
        scan_left        = SCAN_PERIOD_RESET;
        hour_now         = HOUR_W'(15);
        minute_now       = MIN_W'(8);
        second_now       = SEC_W'(50);
        scan_slot        = '0;
        shown_enable_n   = '0;
        shown_segments_n = '0;
        dot_now          = 1'b0;
    endfunction

    // A period write stores the period and restarts its countdown from it.
    function automatic void write_clock_model(t_reg_index index, logic [PERIOD_W-1:0] value);
        if (index == REG_SECOND_PERIOD) begin
            second_reload = value;
            second_left   = value;
        end else begin
            scan_reload = value;
            scan_left   = value;
        end
    endfunction

    function automatic t_readout current_readout();
        return '{shown_enable_n, shown_segments_n, dot_now, hour_now, minute_now, second_now};
    endfunction

    // Advance the model by one beat and return what the display shows after it.
    function automatic t_readout advance_clock_model(logic tick);
        logic       second_hit;
        logic       scan_hit;
        logic [3:0] digit;
        second_hit = 1'b0;
        scan_hit   = 1'b0;
        digit      = '0;
        if (tick) begin
            // A countdown parked at zero neither counts nor fires.
            if (second_left != '0) begin
                second_left = second_left - 1'b1;
                second_hit  = (second_left == '0);
            end
            if (scan_left != '0) begin
                scan_left = scan_left - 1'b1;
                scan_hit  = (scan_left == '0);
            end
            // The time moves first, so a scan in the same beat shows the new time.
            if (second_hit) begin
                second_left = second_reload;
                dot_now     = ~dot_now;
                if (second_now == SEC_W'(59)) begin
                    second_now = '0;
                    if (minute_now == MIN_W'(59)) begin
                        minute_now = '0;
                        if (hour_now == HOUR_W'(23)) begin
                            hour_now  = '0;
                            midnights = midnights + 1;
                        end else begin
                            hour_now = hour_now + 1'b1;
                        end
                    end else begin
                        minute_now = minute_now + 1'b1;
                    end
                end else begin
                    second_now = second_now + 1'b1;
                end
            end
            if (scan_hit) begin
                scan_left = scan_reload;
                case (scan_slot)
                    2'd0:    digit = 4'(hour_now / 10);
                    2'd1:    digit = 4'(hour_now % 10);
                    2'd2:    digit = 4'(minute_now / 10);
                    default: digit = 4'(minute_now % 10);
                endcase
                shown_enable_n   = ~(DIGITS'(1) << scan_slot);
                shown_segments_n = GLYPHS[digit*SEG_W +: SEG_W];
                scan_slot        = scan_slot + 1'b1;
            end
        end
        return current_readout();
    endfunction

    // ------------------------------------------------------------------------
    // Edge monitor. It samples at the rising edge; the inputs
    // were set at the falling edge before, so they are settled.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        t_readout got;
        t_readout want;
        if (!rst_n) begin
            reset_clock_model();
            readouts_due.delete();
        end else begin
            // The result beat taken now belongs to an earlier tick beat, so it
            // is checked before this edge's tick beat adds its expectation.
            if (readout_valid && readout_ready) begin
                got = '{enable_n, segments_n, dot_level, hours, minutes, seconds};
                if (readouts_due.size() == 0) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= REPORT_MAX) begin
                        $display("%0t: stray result en=%h seg=%h dot=%b %0d:%0d:%0d",
                                 $time, got.enable_n, got.segments_n, got.dot,
                                 got.hours, got.minutes, got.seconds);
                    end
                end else begin
                    want    = readouts_due.pop_front();
                    checked = checked + 1;
                    if (got.enable_n !== want.enable_n || got.segments_n !== want.segments_n ||
                        got.dot !== want.dot || got.hours !== want.hours ||
                        got.minutes !== want.minutes || got.seconds !== want.seconds) begin
                        mismatches = mismatches + 1;
                        if (mismatches <= REPORT_MAX) begin
                            $display("%0t: mismatch, expected en=%h seg=%h dot=%b %0d:%0d:%0d",
                                     $time, want.enable_n, want.segments_n, want.dot,
                                     want.hours, want.minutes, want.seconds);
                            $display("%0t:           got      en=%h seg=%h dot=%b %0d:%0d:%0d",
                                     $time, got.enable_n, got.segments_n, got.dot,
                                     got.hours, got.minutes, got.seconds);
                        end
                    end
                end
            end
            if (cfg_we) begin
                write_clock_model(cfg_index, cfg_data);
            end
            if (tick_valid && tick_ready) begin
                want = advance_clock_model(tick_bit);
                // Script rows with a typed value are checked against that value.
                if (row_typed) begin
                    want = row_want;
                end
                readouts_due.push_back(want);
                ticks_sent = ticks_sent + 1;
            end
        end
    end

    // Watchdog: a run that stops moving beats on both channels is a failure.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((tick_valid && tick_ready) || (readout_valid && readout_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles = quiet_cycles + 1;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no beat for %0d cycles, %0d results still due",
                         $time, quiet_cycles, readouts_due.size());
                $display("digital_clock_with_7seg_scan_tb NOT OK");
                $finish;
            end
        end
    end

    // Result side: ready drops at random while idling is enabled, and stays
    // high otherwise.
    always @(negedge clk) begin
        if (stall_left > 0) begin
            stall_left    = stall_left - 1;
            readout_ready = 1'b0;
        end else if (idling_enabled && $urandom_range(0, 5) == 0) begin
            stall_left    = $urandom_range(1, 9) - 1;
            readout_ready = 1'b0;
        end else begin
            readout_ready = 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Driving tasks. Each starts and ends at a falling edge. Valid is left high
    // on return so that back-to-back beats keep it high without a dip.
    // ------------------------------------------------------------------------
    task automatic send_tick(logic tick, bit typed, t_readout want);
        if (idling_enabled && $urandom_range(0, 3) == 0) begin
            tick_valid = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        tick_valid = 1'b1;
        tick_bit   = tick;
        row_typed  = typed;
        row_want   = want;
        do begin
            @(posedge clk);
        end while (!tick_ready);
        @(negedge clk);
    endtask

    // Let every pending result drain before a register is touched. Every beat
    // makes exactly one result, so an empty queue means the block is idle.
    task automatic drain_results();
        tick_valid = 1'b0;
        row_typed  = 1'b0;
        while (readouts_due.size() != 0) @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_period(t_reg_index index, logic [PERIOD_W-1:0] value);
        drain_results();
        cfg_we    = 1'b1;
        cfg_index = index;
        cfg_data  = value;
        @(negedge clk);
        cfg_we      = 1'b0;
        writes_done = writes_done + 1;
    endtask

    // Period mix for the random phases: mostly short, with the edge values
    // and the occasional full-range pick thrown in.
    function automatic logic [PERIOD_W-1:0] pick_period();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return PERIOD_W'(1);
            2:       return '1;
            3:       return PERIOD_W'($urandom_range(0, 65535));
            default: return PERIOD_W'($urandom_range(1, 6));
        endcase
    endfunction

    // Script builders.
    t_script_row script[$];

    function automatic t_readout shows(logic [DIGITS-1:0] en, logic [SEG_W-1:0] seg,
                                       logic dot, int hh, int mm, int ss);
        return '{en, seg, dot, HOUR_W'(hh), MIN_W'(mm), SEC_W'(ss)};
    endfunction

    function automatic void add_tick(logic tick);
        t_script_row row;
        row       = '{ROW_TICK, REG_SECOND_PERIOD, '0, tick, 1'b0, '0};
        script.push_back(row);
    endfunction

    function automatic void add_tick_typed(logic tick, t_readout want);
        t_script_row row;
        row       = '{ROW_TICK, REG_SECOND_PERIOD, '0, tick, 1'b1, want};
        script.push_back(row);
    endfunction

    function automatic void add_write(t_reg_index index, logic [PERIOD_W-1:0] value);
        t_script_row row;
        row       = '{ROW_WRITE, index, value, 1'b0, 1'b0, '0};
        script.push_back(row);
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        // Out of reset all digits are enabled with every segment lit (all
        // enables and segments low) at 15:08:50, and a zero tick leaves it so.
        add_tick_typed(1'b0, shows(4'h0, 7'h00, 1'b0, 15, 8, 50));
        // A single tick only moves the countdowns, nothing visible.
        add_tick_typed(1'b1, shows(4'h0, 7'h00, 1'b0, 15, 8, 50));
        // With both periods at one, every tick moves the time and the scan.
        add_write(REG_SECOND_PERIOD, 16'd1);
        add_write(REG_SCAN_PERIOD, 16'd1);
        add_tick_typed(1'b1, shows(4'hE, 7'h79, 1'b1, 15, 8, 51));
        add_tick_typed(1'b1, shows(4'hD, 7'h12, 1'b0, 15, 8, 52));
        add_tick_typed(1'b0, shows(4'hD, 7'h12, 1'b0, 15, 8, 52));
        add_tick_typed(1'b1, shows(4'hB, 7'h40, 1'b1, 15, 8, 53));
        add_tick_typed(1'b1, shows(4'h7, 7'h00, 1'b0, 15, 8, 54));
        add_tick_typed(1'b1, shows(4'hE, 7'h79, 1'b1, 15, 8, 55));
        // A zero second period freezes the time while the scan keeps going.
        add_write(REG_SECOND_PERIOD, 16'd0);
        add_tick(1'b1);
        add_tick(1'b1);
        add_tick(1'b1);
        // With both periods at zero nothing moves at all.
        add_write(REG_SCAN_PERIOD, 16'd0);
        add_tick(1'b1);
        add_tick(1'b1);
        // Short unequal periods make the two countdowns fire on different ticks.
        add_write(REG_SECOND_PERIOD, 16'd2);
        add_write(REG_SCAN_PERIOD, 16'd3);
        repeat (5) add_tick(1'b1);
        // The longest periods: the countdowns run but cannot expire here.
        add_write(REG_SECOND_PERIOD, 16'hFFFF);
        add_write(REG_SCAN_PERIOD, 16'hFFFF);
        add_tick(1'b1);
        add_tick(1'b0);
        // Back to one tick per second to carry the seconds into a new minute.
        add_write(REG_SECOND_PERIOD, 16'd1);
        add_write(REG_SCAN_PERIOD, 16'd1);
        repeat (6) add_tick(1'b1);

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n          = 1'b1;
        idling_enabled = 1'b1;

        foreach (script[k]) begin
            if (script[k].kind == ROW_WRITE) begin
                write_period(script[k].index, script[k].value);
            end else begin
                send_tick(script[k].tick, script[k].typed, script[k].want);
                directed = directed + 1;
            end
        end

        // Random phases, each with fresh periods. The last two run without
        // idling on either side.
        for (int phase = 0; phase < PHASES; phase++) begin
            idling_enabled = (phase < PHASES - 2);
            if ($urandom_range(0, 1) == 0) begin
                write_period(REG_SECOND_PERIOD, pick_period());
                write_period(REG_SCAN_PERIOD, pick_period());
            end else begin
                write_period(REG_SCAN_PERIOD, pick_period());
                write_period(REG_SECOND_PERIOD, pick_period());
            end
            repeat (PHASE_TICKS) send_tick($urandom_range(0, 6) != 0, 1'b0, '0);
        end

        // Wait out every result, then keep watching for anything stray.
        drain_results();
        repeat (10) @(negedge clk);

        if (readouts_due.size() != 0) begin
            mismatches = mismatches + 1;
        end
        $display(
            "Run covered %0d tick beats (%0d scripted), %0d period writes, %0d results checked.",
            ticks_sent, directed, writes_done, checked);
        $display("The clock passed midnight %0d time(s); %0d mismatch(es) found.",
                 midnights, mismatches);
        if (mismatches == 0) begin
            $display("digital_clock_with_7seg_scan_tb OK");
        end else begin
            $display("digital_clock_with_7seg_scan_tb NOT OK");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/dclk_pkg.sv
rtl/dclk_count_cell.sv
rtl/dclk_countdown.sv
rtl/digital_clock_with_7seg_scan.sv
test/digital_clock_with_7seg_scan_tb.sv
